FILE: hw/rtl/ssb_pkg.sv
// ssb_pkg: shared widths, field offsets, op and register codes and word helpers
// for the subtract-and-skip-if-borrow core.
// No dependencies.
package ssb_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int MAX_NB      = 8;
    localparam int NB_W        = 4;
    localparam int BITCNT_W    = 7;
    localparam int BITIDX_W    = 6;
    localparam int BADDR_W     = 12;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_MAPPED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_LOW_PC = 2'd2;

    localparam logic [NB_W-1:0]   WORD_BYTES_RST = 4'd4;
    localparam logic [WORD_W-1:0] HALT_PC_MAX    = 64'd4;

    // stream layouts
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 144;
    localparam int M_RD_LSB   = 0;
    localparam int M_PC_LSB   = 8;
    localparam int M_ACC_LSB  = 72;
    localparam int M_SKIP_BIT = 136;
    localparam int M_HALT_BIT = 137;

    function automatic logic [NB_W-1:0] eff_bytes(input logic [NB_W-1:0] wb);
        if (wb == '0) begin
            return NB_W'(1);
        end else if (wb > NB_W'(MAX_NB)) begin
            return NB_W'(MAX_NB);
        end
        return wb;
    endfunction

    function automatic logic [WORD_W-1:0] word_mask(input logic [NB_W-1:0] nb);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_NB; i++) begin
            if (NB_W'(i) < nb) begin
                m[i*BYTE_W +: BYTE_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/subtract_skip_borrow_cpu_core.sv
// subtract_skip_borrow_cpu_core: top level of the subtract-and-skip-if-borrow
// machine. Depends on ssb_pkg, ssb_mem and ssb_modred.
//
// Usage:
//   Input stream (i_s_*): one item per command. tuser carries op (0 write byte,
//   1 read byte, 2 run one instruction), tdata carries byte_addr and byte_value.
//   Output stream (o_m_*): one result item per command with read_value,
//   prog_counter, accum, borrow_skip and halted.
//   Config port (i_cfg_*): word_bytes, acc_mapped, halt_low_pc; write only
//   while no command is in flight.
// Sequence (nb = effective word_bytes):
//   byte write/read: 12-bit address reduction, byte access, then PC load.
//   run: word loads and stores, plus an accumulator store when acc_mapped
//   and a second PC update on a skip; paced by the byte-wide memory port and
//   the bit-serial address reduction (8*nb bits per address, two per run).
//   One command at a time; the next is taken as soon as the result sits in
//   the output register, even if the receiver stalls it there.
// Reset: synchronous, active low. Afterwards the memory is zero-filled,
//   with o_s_tready low; config registers go to defaults.
module subtract_skip_borrow_cpu_core #(
    parameter int MEM_BYTES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ssb_pkg::S_TDATA_W-1:0]      i_s_tdata,  // byte_addr, byte_value
    input  logic [ssb_pkg::S_TUSER_W-1:0]      i_s_tuser,  // op
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // read_value, prog_counter, accum, borrow_skip, halted
    output logic [ssb_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ssb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int BW = ssb_pkg::BYTE_W;
    localparam int WW = ssb_pkg::WORD_W;
    localparam int NBW = ssb_pkg::NB_W;

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE    = 5'd0;
    localparam logic [SW-1:0] S_RED_BA  = 5'd1;
    localparam logic [SW-1:0] S_BYTE    = 5'd2;
    localparam logic [SW-1:0] S_BYTE_RD = 5'd3;
    localparam logic [SW-1:0] S_LD_PC   = 5'd4;
    localparam logic [SW-1:0] S_HCHK    = 5'd5;
    localparam logic [SW-1:0] S_ST_PC   = 5'd6;
    localparam logic [SW-1:0] S_RED_PC  = 5'd7;
    localparam logic [SW-1:0] S_LD_OPA  = 5'd8;
    localparam logic [SW-1:0] S_RED_OPA = 5'd9;
    localparam logic [SW-1:0] S_LD_DAT  = 5'd10;
    localparam logic [SW-1:0] S_ST_RES  = 5'd11;
    localparam logic [SW-1:0] S_ST_MAP  = 5'd12;
    localparam logic [SW-1:0] S_LD_P2   = 5'd13;
    localparam logic [SW-1:0] S_ST_P2   = 5'd14;
    localparam logic [SW-1:0] S_LD_FIN  = 5'd15;
    localparam logic [SW-1:0] S_OUT     = 5'd16;

    // control
    logic [SW-1:0]  r_state;
    logic [NBW-1:0] r_cnt;
    logic           r_ovalid;
    logic [NBW-1:0] r_word_bytes;
    logic           r_acc_mapped;
    logic           r_halt_low;
    logic [WW-1:0]  r_acc;

    // payload
    logic [ssb_pkg::OP_W-1:0]    r_op;
    logic [ssb_pkg::BADDR_W-1:0] r_baddr;
    logic [BW-1:0]  r_bval;
    logic [AW-1:0]  r_base;
    logic [WW-1:0]  r_pc;
    logic [WW-1:0]  r_ld;
    logic [WW-1:0]  r_res;
    logic           r_carry;
    logic           r_skip;
    logic           r_halt;
    logic [BW-1:0]  r_rd;
    logic [BW-1:0]  r_o_rd;
    logic [WW-1:0]  r_o_pc;
    logic [WW-1:0]  r_o_acc;
    logic           r_o_skip;
    logic           r_o_halt;

    logic [NBW-1:0] nb;
    logic [2:0]     cnt3;
    logic [NBW-1:0] st_off4;
    logic [2:0]     off;
    logic [AW:0]    addr_sum;
    logic [AW-1:0]  mem_addr;
    logic           is_load;
    logic           is_store;
    logic           is_red;
    logic [WW-1:0]  a_word;
    logic [WW-1:0]  b_word;
    logic [BW-1:0]  a_byte;
    logic [BW-1:0]  b_byte;
    logic [BW:0]    alu9;
    logic [WW-1:0]  n_res;
    logic [WW-1:0]  n_ld;
    logic           acc_hi;
    logic           skip_now;
    logic           mem_we;
    logic [BW-1:0]  mem_wdata;
    logic [BW-1:0]  mem_rdata;
    logic           mem_busy;
    logic           red_start;
    logic [WW-1:0]  red_value;
    logic [ssb_pkg::BITCNT_W-1:0] red_nbits;
    logic [AW-1:0]  red_rem;
    logic           red_busy;
    logic           s_accept;

    assign nb       = ssb_pkg::eff_bytes(r_word_bytes);
    assign cnt3     = r_cnt[2:0];
    assign st_off4  = nb - NBW'(1) - r_cnt;

    assign is_load  = (r_state == S_LD_PC) || (r_state == S_LD_OPA) || (r_state == S_LD_DAT)
                   || (r_state == S_LD_P2) || (r_state == S_LD_FIN);
    assign is_store = (r_state == S_ST_PC) || (r_state == S_ST_RES) || (r_state == S_ST_MAP)
                   || (r_state == S_ST_P2);
    assign is_red   = (r_state == S_RED_BA) || (r_state == S_RED_PC) || (r_state == S_RED_OPA);

    // big-endian words: loads walk up from the base, stores walk down from the LSB
    assign off      = is_store ? st_off4[2:0] : (is_load ? cnt3 : 3'd0);
    assign addr_sum = {1'b0, r_base} + (AW + 1)'(off);
    assign mem_addr = (addr_sum >= (AW + 1)'(MEM_BYTES))
                    ? AW'(addr_sum - (AW + 1)'(MEM_BYTES)) : addr_sum[AW-1:0];

    always_comb begin
        a_word = '0;
        b_word = '0;
        unique case (r_state)
            S_ST_PC: begin
                a_word = r_pc;
                b_word = WW'(nb);
            end
            S_ST_RES: begin
                a_word = r_ld;
                b_word = r_acc;
            end
            S_ST_MAP: begin
                a_word = r_acc;
            end
            S_ST_P2: begin
                a_word = r_ld;
                b_word = WW'(nb);
            end
            default: begin
            end
        endcase
    end

    assign a_byte = a_word[{cnt3, 3'b000} +: BW];
    assign b_byte = b_word[{cnt3, 3'b000} +: BW];
    assign alu9   = (r_state == S_ST_RES)
                  ? ({1'b0, a_byte} - {1'b0, b_byte} - (BW + 1)'(r_carry))
                  : ({1'b0, a_byte} + {1'b0, b_byte} + (BW + 1)'(r_carry));

    always_comb begin
        n_res = r_res;
        n_res[{cnt3, 3'b000} +: BW] = alu9[BW-1:0];
    end

    assign n_ld     = (r_cnt != '0) ? {r_ld[WW-BW-1:0], mem_rdata} : r_ld;
    assign acc_hi   = |(r_acc & ~ssb_pkg::word_mask(nb));
    assign skip_now = alu9[BW] | acc_hi;

    assign mem_we    = is_store || ((r_state == S_BYTE) && (r_op == ssb_pkg::OP_WRITE));
    assign mem_wdata = is_store ? alu9[BW-1:0] : r_bval;

    assign red_start = is_red && (r_cnt == '0);
    always_comb begin
        red_value = r_ld;
        red_nbits = {nb, 3'b000};
        priority case (r_state)
            S_RED_BA: begin
                red_value = WW'(r_baddr);
                red_nbits = ssb_pkg::BITCNT_W'(ssb_pkg::BADDR_W);
            end
            S_RED_PC: red_value = r_pc;
            default: begin
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE) && !mem_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;

    ssb_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    ssb_modred #(.MEM_BYTES(MEM_BYTES)) u_modred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_value (red_value),
        .i_nbits (red_nbits),
        .o_rem   (red_rem),
        .o_busy  (red_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_ovalid     <= 1'b0;
            r_acc        <= '0;
            r_word_bytes <= ssb_pkg::WORD_BYTES_RST;
            r_acc_mapped <= 1'b0;
            r_halt_low   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ssb_pkg::CFG_WORD_BYTES:  r_word_bytes <= i_cfg_data;
                    ssb_pkg::CFG_ACC_MAPPED:  r_acc_mapped <= i_cfg_data[0];
                    ssb_pkg::CFG_HALT_LOW_PC: r_halt_low   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // S_OUT reloads the output register itself
            if (r_ovalid && i_m_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            if (is_load) begin
                r_ld <= n_ld;
                if (r_cnt == nb) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + NBW'(1);
                end
            end

            if (is_store) begin
                r_res <= n_res;
                if (r_cnt == nb - NBW'(1)) begin
                    r_cnt   <= '0;
                    r_carry <= 1'b0;
                    r_ld    <= '0;
                end else begin
                    r_cnt   <= r_cnt + NBW'(1);
                    r_carry <= alu9[BW];
                end
            end

            if (is_red) begin
                if (r_cnt == '0) begin
                    r_cnt <= NBW'(1);
                end else if (!red_busy) begin
                    r_cnt  <= '0;
                    r_base <= red_rem;
                    r_ld   <= '0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_op    <= i_s_tuser[ssb_pkg::OP_W-1:0];
                        r_baddr <= i_s_tdata[ssb_pkg::BADDR_W-1:0];
                        r_bval  <= i_s_tdata[ssb_pkg::BADDR_W +: BW];
                        r_base  <= '0;
                        r_cnt   <= '0;
                        r_ld    <= '0;
                        r_carry <= 1'b0;
                        r_rd    <= '0;
                        r_skip  <= 1'b0;
                        r_halt  <= 1'b0;
                        unique case (i_s_tuser[ssb_pkg::OP_W-1:0])
                            ssb_pkg::OP_WRITE: r_state <= S_RED_BA;
                            ssb_pkg::OP_READ:  r_state <= S_RED_BA;
                            ssb_pkg::OP_RUN:   r_state <= S_LD_PC;
                            default:           r_state <= S_LD_FIN;
                        endcase
                    end
                end
                S_RED_BA: begin
                    if (r_cnt != '0 && !red_busy) begin
                        r_state <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    r_state <= S_BYTE_RD;
                end
                S_BYTE_RD: begin
                    if (r_op == ssb_pkg::OP_READ) begin
                        r_rd <= mem_rdata;
                    end
                    r_base  <= '0;
                    r_cnt   <= '0;
                    r_ld    <= '0;
                    r_state <= S_LD_FIN;
                end
                S_LD_PC: begin
                    if (r_cnt == nb) begin
                        r_pc    <= n_ld;
                        r_state <= S_HCHK;
                    end
                end
                S_HCHK: begin
                    r_base <= '0;
                    r_cnt  <= '0;
                    r_ld   <= '0;
                    if (r_halt_low && (r_pc <= ssb_pkg::HALT_PC_MAX)) begin
                        r_halt  <= 1'b1;
                        r_state <= S_LD_FIN;
                    end else begin
                        r_carry <= 1'b0;
                        r_state <= S_ST_PC;
                    end
                end
                S_ST_PC: begin
                    if (r_cnt == nb - NBW'(1)) begin
                        r_state <= S_RED_PC;
                    end
                end
                S_RED_PC: begin
                    if (r_cnt != '0 && !red_busy) begin
                        r_state <= S_LD_OPA;
                    end
                end
                S_LD_OPA: begin
                    if (r_cnt == nb) begin
                        r_state <= S_RED_OPA;
                    end
                end
                S_RED_OPA: begin
                    if (r_cnt != '0 && !red_busy) begin
                        r_state <= S_LD_DAT;
                    end
                end
                S_LD_DAT: begin
                    if (r_cnt == nb) begin
                        r_res   <= '0;
                        r_carry <= 1'b0;
                        r_state <= S_ST_RES;
                    end
                end
                S_ST_RES: begin
                    if (r_cnt == nb - NBW'(1)) begin
                        r_acc  <= n_res;
                        r_skip <= skip_now;
                        if (r_acc_mapped) begin
                            r_base  <= AW'(nb);
                            r_state <= S_ST_MAP;
                        end else begin
                            r_base  <= '0;
                            r_state <= skip_now ? S_LD_P2 : S_LD_FIN;
                        end
                    end
                end
                S_ST_MAP: begin
                    if (r_cnt == nb - NBW'(1)) begin
                        r_base  <= '0;
                        r_state <= r_skip ? S_LD_P2 : S_LD_FIN;
                    end
                end
                S_LD_P2: begin
                    if (r_cnt == nb) begin
                        r_state <= S_ST_P2;
                    end
                end
                S_ST_P2: begin
                    if (r_cnt == nb - NBW'(1)) begin
                        r_state <= S_LD_FIN;
                    end
                end
                S_LD_FIN: begin
                    if (r_cnt == nb) begin
                        r_pc    <= n_ld;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_o_rd   <= r_rd;
                        r_o_pc   <= r_pc;
                        r_o_acc  <= r_acc;
                        r_o_skip <= r_skip;
                        r_o_halt <= r_halt;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b000000, r_o_halt, r_o_skip, r_o_acc, r_o_pc, r_o_rd};

endmodule

FILE: hw/rtl/ssb_mem.sv
// ssb_mem: byte-wide main memory, one write and one registered read port,
// with a zero-fill sweep after reset. Depends on ssb_pkg.
module ssb_mem #(
    parameter int MEM_BYTES = 4096,
    localparam int AW = $clog2(MEM_BYTES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ssb_pkg::BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [ssb_pkg::BYTE_W-1:0] o_rdata,
    output logic                      o_busy
);

    logic [ssb_pkg::BYTE_W-1:0] r_mem [MEM_BYTES];
    logic                       r_clearing;
    logic [AW-1:0]              r_clr_addr;
    logic [ssb_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(MEM_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

FILE: hw/rtl/ssb_modred.sv
// ssb_modred: bit-serial reduction of a word modulo MEM_BYTES, MSB first,
// one bit per cycle. Depends on ssb_pkg.
module ssb_modred #(
    parameter int MEM_BYTES = 4096,
    localparam int AW = $clog2(MEM_BYTES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ssb_pkg::WORD_W-1:0]    i_value,
    input  logic [ssb_pkg::BITCNT_W-1:0]  i_nbits,
    output logic [AW-1:0]                 o_rem,
    output logic                          o_busy
);

    localparam int RW = AW + 1;

    logic                          r_busy;
    logic [ssb_pkg::BITIDX_W-1:0]  r_idx;
    logic [ssb_pkg::WORD_W-1:0]    r_val;
    logic [AW-1:0]                 r_rem;
    logic [RW-1:0]                 dbl;
    logic [RW-1:0]                 red;

    assign dbl = {r_rem, r_val[r_idx]};
    assign red = (dbl >= RW'(MEM_BYTES)) ? dbl - RW'(MEM_BYTES) : dbl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= ssb_pkg::BITIDX_W'(i_nbits - ssb_pkg::BITCNT_W'(1));
        end else if (r_busy) begin
            if (r_idx == '0) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx - ssb_pkg::BITIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= red[AW-1:0];
        end
    end

    assign o_rem  = r_rem;
    assign o_busy = r_busy;

endmodule

FILE: hw/rtl/ssb_checker.sv
// ssb_checker: port-level assertions for subtract_skip_borrow_cpu_core, and
// the bind that attaches them. Depends on ssb_pkg.
module ssb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [ssb_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    // reset drops any result and holds off input during the memory fill
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("outputs active right after reset");

    // one item in flight: accepting an item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or dropped");

    // a halted run does no subtraction and reads no byte
    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[ssb_pkg::M_HALT_BIT]
        |-> !o_m_tdata[ssb_pkg::M_SKIP_BIT]
            && (o_m_tdata[ssb_pkg::M_RD_LSB +: ssb_pkg::BYTE_W] == '0))
        else $error("halted result with skip or read data");

endmodule

bind subtract_skip_borrow_cpu_core ssb_checker u_ssb_checker (.*);

FILE: bench/tb_subtract_skip_borrow_cpu_core.sv
// tb_subtract_skip_borrow_cpu_core: self-checking bench for the one-instruction
// subtract-and-skip-if-borrow core; predicts every result item from its own model.
// Depends on ssb_pkg and subtract_skip_borrow_cpu_core.
module tb_subtract_skip_borrow_cpu_core;

    localparam int MEM_SIZE    = 4096;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [ssb_pkg::OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [7:0]  rd;
        logic [63:0] pc;
        logic [63:0] acc;
        logic        skip;
        logic        halt;
    } t_cpu_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ssb_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [ssb_pkg::S_TUSER_W-1:0]  s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ssb_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_we = 1'b0;
    logic [ssb_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [ssb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    subtract_skip_borrow_cpu_core #(
        .MEM_BYTES (MEM_SIZE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // machine image
    logic [7:0]  mem_img [MEM_SIZE];
    logic [63:0] acc_img = '0;
    logic [3:0]  cfg_wb = ssb_pkg::WORD_BYTES_RST;
    logic        cfg_mapped = 1'b0;
    logic        cfg_halt = 1'b1;

    t_cpu_result due_results[$];

    int errors = 0;
    int items_sent = 0;
    int n_exec = 0;
    int n_skip = 0;
    int n_halt = 0;
    int n_settings = 0;
    int cycles = 0;
    int burst_left = 0;

    int hold_req = 0;
    int stall_left = 0;
    int rx_mode = 0;
    int rx_left = 0;

    t_cpu_result got_r;
    t_cpu_result want_r;

    function automatic int active_word_bytes();
        if (cfg_wb == 4'd0) begin
            return 1;
        end
        if (cfg_wb > 4'd8) begin
            return 8;
        end
        return int'(cfg_wb);
    endfunction

    function automatic logic [63:0] width_mask(int nb);
        if (nb >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * nb)) - 64'd1;
    endfunction

    function automatic logic [63:0] mem_get_word(logic [63:0] addr, int nb);
        logic [11:0] base;
        logic [63:0] v;
        base = addr[11:0];
        v = '0;
        for (int i = 0; i < nb; i++) begin
            v = (v << 8) | 64'(mem_img[12'(base + i)]);
        end
        return v;
    endfunction

    function automatic void mem_put_word(logic [63:0] addr, int nb, logic [63:0] v);
        logic [11:0] base;
        base = addr[11:0];
        for (int i = 0; i < nb; i++) begin
            mem_img[12'(base + i)] = 8'(v >> (8 * (nb - 1 - i)));
        end
    endfunction

    function automatic t_cpu_result exec_cmd(logic [1:0] op, logic [11:0] addr,
                                             logic [7:0] val);
        t_cpu_result r;
        int nb;
        logic [63:0] m, pc, opa, data, res;
        nb = active_word_bytes();
        m = width_mask(nb);
        r = '0;
        case (op)
            ssb_pkg::OP_WRITE: mem_img[addr] = val;
            ssb_pkg::OP_READ:  r.rd = mem_img[addr];
            ssb_pkg::OP_RUN: begin
                pc = mem_get_word(64'd0, nb);
                if (cfg_halt && pc <= ssb_pkg::HALT_PC_MAX) begin
                    r.halt = 1'b1;
                    n_halt++;
                end else begin
                    n_exec++;
                    mem_put_word(64'd0, nb, (pc + 64'(nb)) & m);
                    opa = mem_get_word(pc, nb);
                    data = mem_get_word(opa, nb);
                    r.skip = (data < acc_img);
                    res = (data - acc_img) & m;
                    acc_img = res;
                    mem_put_word(opa, nb, res);
                    if (cfg_mapped) begin
                        mem_put_word(64'(nb), nb, res);
                    end
                    if (r.skip) begin
                        n_skip++;
                        pc = mem_get_word(64'd0, nb);
                        mem_put_word(64'd0, nb, (pc + 64'(nb)) & m);
                    end
                end
            end
            default: ;
        endcase
        r.pc = mem_get_word(64'd0, nb);
        r.acc = acc_img;
        return r;
    endfunction

    // sender: bursts with random gaps, one item per call
    task automatic send_cmd(logic [1:0] op, logic [11:0] addr, logic [7:0] val);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2, 3, 4: gap = $urandom_range(1, 8);
                default: gap = $urandom_range(1, 150);
            endcase
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, val, addr};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        due_results.push_back(exec_cmd(op, addr, val));
        items_sent++;
    endtask

    task automatic send_word(logic [63:0] addr, logic [63:0] v, int nb);
        for (int i = 0; i < nb; i++) begin
            send_cmd(ssb_pkg::OP_WRITE, 12'(addr + 64'(i)), 8'(v >> (8 * (nb - 1 - i))));
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(logic [3:0] wb, logic mapped, logic halt);
        wait_idle();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= ssb_pkg::CFG_WORD_BYTES;
        cfg_data <= wb;
        cfg_wb = wb;
        @(negedge i_clk);
        cfg_idx  <= ssb_pkg::CFG_ACC_MAPPED;
        cfg_data <= ssb_pkg::CFG_DATA_W'(mapped);
        cfg_mapped = mapped;
        @(negedge i_clk);
        cfg_idx  <= ssb_pkg::CFG_HALT_LOW_PC;
        cfg_data <= ssb_pkg::CFG_DATA_W'(halt);
        cfg_halt = halt;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // PC, a few operand words, their data, then a run of instructions with noise
    task automatic load_and_run_program();
        int nb, k, runs;
        logic [63:0] pc_val, dval;
        logic [63:0] opnds[8];
        nb = active_word_bytes();
        k = (nb > 4) ? $urandom_range(1, 3) : $urandom_range(2, 6);
        case ($urandom_range(0, 3))
            0:       pc_val = 64'($urandom_range(5, 64));
            1:       pc_val = 64'($urandom_range(256, 3500));
            2:       pc_val = 64'(MEM_SIZE - $urandom_range(1, 8));
            default: pc_val = {$urandom, $urandom};
        endcase
        send_word(64'd0, pc_val, nb);
        for (int j = 0; j < k; j++) begin
            case ($urandom_range(0, 5))
                0, 1:    opnds[j] = 64'(3072 + $urandom_range(0, 255));
                2:       opnds[j] = 64'(nb);
                3:       opnds[j] = 64'd0;
                4:       opnds[j] = 64'(MEM_SIZE - $urandom_range(1, 4));
                default: opnds[j] = {$urandom, $urandom};
            endcase
            send_word(pc_val + 64'(j * nb), opnds[j], nb);
        end
        for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 3) != 0) begin
                dval = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 3))
                                                   : {$urandom, $urandom};
                send_word(opnds[j], dval, nb);
            end
        end
        runs = k + $urandom_range(0, 3);
        for (int j = 0; j < runs; j++) begin
            case ($urandom_range(0, 9))
                0: send_cmd(2'($urandom_range(0, 3)), 12'($urandom), 8'($urandom));
                1: send_cmd(ssb_pkg::OP_READ, 12'(pc_val + 64'($urandom_range(0, 15))),
                            8'($urandom));
                default: ;
            endcase
            send_cmd(ssb_pkg::OP_RUN, 12'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_reset_halt();
        send_cmd(ssb_pkg::OP_RUN, 12'hFFF, 8'hFF);
        send_cmd(OP_NONE, 12'hFFF, 8'hFF);
        send_cmd(ssb_pkg::OP_READ, 12'h000, 8'h00);
    endtask

    task automatic test_field_extremes();
        send_cmd(ssb_pkg::OP_WRITE, 12'hFFF, 8'hFF);
        send_cmd(ssb_pkg::OP_READ, 12'hFFF, 8'h00);
        send_cmd(ssb_pkg::OP_WRITE, 12'h800, 8'h00);
        send_cmd(ssb_pkg::OP_READ, 12'h800, 8'hFF);
        send_cmd(ssb_pkg::OP_WRITE, 12'h555, 8'hAA);
        send_cmd(ssb_pkg::OP_READ, 12'h555, 8'h55);
    endtask

    task automatic test_halt_boundary();
        send_cmd(ssb_pkg::OP_WRITE, 12'd3, 8'd4);
        send_cmd(ssb_pkg::OP_RUN, 12'd0, 8'd0);
        send_cmd(ssb_pkg::OP_WRITE, 12'd3, 8'd5);
        send_cmd(ssb_pkg::OP_RUN, 12'd0, 8'd0);
        send_cmd(ssb_pkg::OP_RUN, 12'd0, 8'd0);
        send_cmd(ssb_pkg::OP_RUN, 12'd0, 8'd0);
    endtask

    // PC near the top of memory: operand word wraps into address 0
    task automatic test_address_wrap();
        send_cmd(ssb_pkg::OP_WRITE, 12'd0, 8'd0);
        send_cmd(ssb_pkg::OP_WRITE, 12'd1, 8'd0);
        send_cmd(ssb_pkg::OP_WRITE, 12'd2, 8'h0F);
        send_cmd(ssb_pkg::OP_WRITE, 12'd3, 8'hFE);
        send_cmd(ssb_pkg::OP_RUN, 12'd0, 8'd0);
        send_cmd(ssb_pkg::OP_READ, 12'd1, 8'd0);
    endtask

    task automatic test_config_sweep();
        logic [3:0] wb_list[11] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd2, 4'd3, 4'd9,
                                    4'd6, 4'd5, 4'd7, 4'd4};
        logic mapped_list[11] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                  1'b1, 1'b0, 1'b1};
        logic halt_list[11]   = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                                  1'b1, 1'b0, 1'b1};
        int start;
        for (int p = 0; p < 11; p++) begin
            set_config(wb_list[p], mapped_list[p], halt_list[p]);
            start = items_sent;
            while (items_sent - start < 20) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_cmd(2'($urandom_range(0, 3)), 12'($urandom), 8'($urandom));
                end else begin
                    load_and_run_program();
                end
            end
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_stall();
        set_config(4'd4, 1'b1, 1'b0);
        hold_req = 700;
        load_and_run_program();
        load_and_run_program();
    endtask

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_r.rd   = m_tdata[ssb_pkg::M_RD_LSB +: 8];
            got_r.pc   = m_tdata[ssb_pkg::M_PC_LSB +: 64];
            got_r.acc  = m_tdata[ssb_pkg::M_ACC_LSB +: 64];
            got_r.skip = m_tdata[ssb_pkg::M_SKIP_BIT];
            got_r.halt = m_tdata[ssb_pkg::M_HALT_BIT];
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result item: rd=%h pc=%h acc=%h skip=%b halt=%b",
                             got_r.rd, got_r.pc, got_r.acc, got_r.skip, got_r.halt);
                end
            end else begin
                want_r = due_results.pop_front();
                if (got_r.rd !== want_r.rd || got_r.pc !== want_r.pc ||
                    got_r.acc !== want_r.acc || got_r.skip !== want_r.skip ||
                    got_r.halt !== want_r.halt) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp rd=%h pc=%h acc=%h skip=%b halt=%b",
                                 want_r.rd, want_r.pc, want_r.acc, want_r.skip, want_r.halt);
                        $display("          got rd=%h pc=%h acc=%h skip=%b halt=%b",
                                 got_r.rd, got_r.pc, got_r.acc, got_r.skip, got_r.halt);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d result items outstanding", due_results.size());
            $display("subtract_skip_borrow_cpu_core test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MEM_SIZE; i++) begin
            mem_img[i] = 8'h00;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_halt();
        test_field_extremes();
        test_halt_boundary();
        test_address_wrap();
        test_config_sweep();
        test_output_stall();

        wait_idle();
        repeat (300) @(posedge i_clk);

        $display("%0d items over %0d register settings after reset defaults", items_sent,
                 n_settings);
        $display("%0d instructions run, %0d borrow skips, %0d refused by halt mode",
                 n_exec, n_skip, n_halt);
        if (errors == 0 && due_results.size() == 0) begin
            $display("subtract_skip_borrow_cpu_core test passed");
        end else begin
            $display("%0d mismatches, %0d items left", errors, due_results.size());
            $display("subtract_skip_borrow_cpu_core test failed");
        end
        $finish;
    end

endmodule
